>>> rtl/pkds_pkg.sv
package pkds_pkg;

    // Field widths
    localparam int TICK_W  = 32;
    localparam int LEVEL_W = 32;
    localparam int COUNT_W = 8;
    localparam int COEFF_W = 16;
    localparam int RATIO_W = 16;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    typedef logic [TICK_W-1:0]  tick_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [COEFF_W-1:0] coeff_t;

    localparam level_t LEVEL_MAX = '1;
    localparam tick_t  TICK_MAX  = '1;

    // Register map, word index into the APB space
    typedef enum logic [2:0] {
        REG_FIRST_DOSE_TICK  = 3'd0,
        REG_DOSE_INTERVAL    = 3'd1,
        REG_MAX_DOSES        = 3'd2,
        REG_LOADING_DOSES    = 3'd3,
        REG_LOADING_INC      = 3'd4,
        REG_MAINT_INC        = 3'd5,
        REG_ELIM_COEFF       = 3'd6,
        REG_FLUX_COEFF       = 3'd7
    } cfg_reg_t;

endpackage

>>> rtl/pkds_tick_if.sv
interface pkds_tick_if
    import pkds_pkg::*;
;
    logic  valid;
    logic  ready;
    tick_t current_tick;

    modport source (output valid, output current_tick, input ready);
    modport sink   (input valid, input current_tick, output ready);
endinterface

>>> rtl/pkds_level_if.sv
interface pkds_level_if
    import pkds_pkg::*;
;
    logic   valid;
    logic   ready;
    level_t central_level;
    level_t periphery_level;
    logic   dose_given;
    count_t doses_so_far;

    modport source (output valid, output central_level, output periphery_level,
                    output dose_given, output doses_so_far, input ready);
    modport sink   (input valid, input central_level, input periphery_level,
                    input dose_given, input doses_so_far, output ready);
endinterface

>>> rtl/pk_dosing_two_compartment_step_unit.sv
// Channel   Dir  Payload                                            Request
// -------   ---  -------------------------------------------------  ---------------------
// tick_in   in   current_tick[31:0]                                 valid & ready
// level_out out  central_level, periphery_level, dose_given, count  valid & ready
// apb       in   8 x 32-bit registers at 4*i                        psel&penable&pwrite
//
// One request per cycle unless level_out stalls. Dose decision and Euler step are
// computed in the cycle of acceptance; the result register takes them at that edge, the
// state registers too unless an APB write comes; the result shows in the next cycle.
// The single result register decouples the sides: tick_in is ready when it is empty or
// being drained. rst_n clears config (interval to 1), dose schedule, levels, out valid.
module pk_dosing_two_compartment_step_unit
    import pkds_pkg::*;
#(
    parameter int unsigned VOLUME_RATIO_Q8 = 256
)(
    input  logic               clk,
    input  logic               rst_n,
    pkds_tick_if.sink          tick_in,
    pkds_level_if.source       level_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam logic [RATIO_W-1:0] RATIO = RATIO_W'(VOLUME_RATIO_Q8);

    // Configuration registers
    tick_t  first_dose_tick_reg;
    tick_t  dose_interval_reg;
    count_t max_doses_reg;
    count_t loading_doses_reg;
    level_t loading_inc_reg;
    level_t maint_inc_reg;
    coeff_t elim_coeff_reg;
    coeff_t flux_coeff_reg;

    // Model state
    tick_t  next_dose_tick_reg, next_dose_tick_next;
    count_t dose_count_reg, dose_count_next;
    level_t central_reg, central_next;
    level_t periphery_reg, periphery_next;

    // Result register
    logic   out_valid_reg;
    level_t out_central_reg;
    level_t out_periphery_reg;
    logic   out_dosed_reg;
    count_t out_count_reg;

    logic     accept;
    logic     cfg_write;
    cfg_reg_t cfg_sel;

    // Dose path
    logic          dose_due;
    level_t        dose_inc;
    logic [32:0]   dose_sum;
    logic [32:0]   sched_sum;
    level_t        c_level;

    // Euler step
    logic        [47:0] e_prod;
    level_t             e_val;
    logic signed [32:0] gap;
    logic signed [49:0] q_prod;
    logic signed [33:0] q_val;
    logic signed [35:0] nc;
    logic signed [50:0] r_prod;
    logic signed [43:0] np;

    assign accept    = tick_in.valid && tick_in.ready;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = cfg_reg_t'(paddr[4:2]);
    assign pready    = 1'b1;

    // Dose decision and increase
    always_comb
    begin
        dose_due  = (tick_in.current_tick >= next_dose_tick_reg) &&
                    (dose_count_reg < max_doses_reg);
        dose_inc  = (dose_count_reg < loading_doses_reg) ? loading_inc_reg : maint_inc_reg;
        dose_sum  = {1'b0, central_reg} + {1'b0, dose_inc};
        sched_sum = {1'b0, next_dose_tick_reg} + {1'b0, dose_interval_reg};
        if (dose_due)
        begin
            c_level             = dose_sum[32] ? LEVEL_MAX : dose_sum[31:0];
            next_dose_tick_next = sched_sum[32] ? TICK_MAX : sched_sum[31:0];
            dose_count_next     = dose_count_reg + count_t'(1);
        end
        else
        begin
            c_level             = central_reg;
            next_dose_tick_next = next_dose_tick_reg;
            dose_count_next     = dose_count_reg;
        end
    end

    // Two-compartment Euler step with floor rounding, clamped to the level range
    always_comb
    begin
        e_prod = {32'd0, elim_coeff_reg} * {16'd0, c_level};
        e_val  = e_prod[47:16];
        gap    = $signed({1'b0, c_level}) - $signed({1'b0, periphery_reg});
        q_prod = $signed({{34{1'b0}}, flux_coeff_reg}) * $signed({{17{gap[32]}}, gap});
        q_val  = q_prod[49:16];
        nc     = $signed({4'd0, c_level}) - $signed({4'd0, e_val})
                 - $signed({{2{q_val[33]}}, q_val});
        r_prod = $signed({{17{q_val[33]}}, q_val}) * $signed({{35{1'b0}}, RATIO});
        np     = $signed({12'd0, periphery_reg}) + $signed({r_prod[50], r_prod[50:8]});

        if (nc[35])
            central_next = '0;
        else if (nc[34:32] != 3'd0)
            central_next = LEVEL_MAX;
        else
            central_next = nc[31:0];

        if (np[43])
            periphery_next = '0;
        else if (np[42:32] != 11'd0)
            periphery_next = LEVEL_MAX;
        else
            periphery_next = np[31:0];
    end

    // Configuration and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_dose_tick_reg <= '0;
            dose_interval_reg   <= tick_t'(1);
            max_doses_reg       <= '0;
            loading_doses_reg   <= '0;
            loading_inc_reg     <= '0;
            maint_inc_reg       <= '0;
            elim_coeff_reg      <= '0;
            flux_coeff_reg      <= '0;
            next_dose_tick_reg  <= '0;
            dose_count_reg      <= '0;
            central_reg         <= '0;
            periphery_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_FIRST_DOSE_TICK:
                begin
                    first_dose_tick_reg <= pwdata;
                    if (dose_count_reg == '0)
                        next_dose_tick_reg <= pwdata;
                end
                REG_DOSE_INTERVAL: dose_interval_reg <= pwdata;
                REG_MAX_DOSES:     max_doses_reg     <= pwdata[COUNT_W-1:0];
                REG_LOADING_DOSES: loading_doses_reg <= pwdata[COUNT_W-1:0];
                REG_LOADING_INC:   loading_inc_reg   <= pwdata;
                REG_MAINT_INC:     maint_inc_reg     <= pwdata;
                REG_ELIM_COEFF:    elim_coeff_reg    <= pwdata[COEFF_W-1:0];
                REG_FLUX_COEFF:    flux_coeff_reg    <= pwdata[COEFF_W-1:0];
            endcase
        end
        else if (accept)
        begin
            next_dose_tick_reg <= next_dose_tick_next;
            dose_count_reg     <= dose_count_next;
            central_reg        <= central_next;
            periphery_reg      <= periphery_next;
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_sel)
            REG_FIRST_DOSE_TICK: prdata = first_dose_tick_reg;
            REG_DOSE_INTERVAL:   prdata = dose_interval_reg;
            REG_MAX_DOSES:       prdata = {24'd0, max_doses_reg};
            REG_LOADING_DOSES:   prdata = {24'd0, loading_doses_reg};
            REG_LOADING_INC:     prdata = loading_inc_reg;
            REG_MAINT_INC:       prdata = maint_inc_reg;
            REG_ELIM_COEFF:      prdata = {16'd0, elim_coeff_reg};
            REG_FLUX_COEFF:      prdata = {16'd0, flux_coeff_reg};
        endcase
    end

    // Result register handshake
    assign tick_in.ready = !out_valid_reg || level_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (level_out.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_central_reg   <= central_next;
            out_periphery_reg <= periphery_next;
            out_dosed_reg     <= dose_due;
            out_count_reg     <= dose_count_next;
        end
    end

    assign level_out.valid           = out_valid_reg;
    assign level_out.central_level   = out_central_reg;
    assign level_out.periphery_level = out_periphery_reg;
    assign level_out.dose_given      = out_dosed_reg;
    assign level_out.doses_so_far    = out_count_reg;

endmodule
